/* rtl/core/alps_pkg.sv */
package alps_pkg;

   localparam int CSR_BITS   = 13;
   localparam int COLOR_BITS = 32;
   localparam int CHAN_BITS  = 8;

   localparam logic [CSR_BITS-1:0]  WIDTH_RESET  = 13'd1024;
   localparam logic [CSR_BITS-1:0]  HEIGHT_RESET = 13'd768;
   localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      REQ_LOAD    = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_kind_type;

   // Classification of one queued item.
   typedef struct packed {
      req_kind_type kind;
      logic         vertical;
      logic         steep;
      logic         negative;
   } line_class_type;

endpackage

/* rtl/core/alps_front.sv */
module alps_front #(
   parameter int COORD_BITS = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  alps_pkg::req_kind_type           req_type,
   input  logic signed [COORD_BITS-1:0]     req_start_x,
   input  logic signed [COORD_BITS-1:0]     req_start_y,
   input  logic signed [COORD_BITS-1:0]     req_end_x,
   input  logic signed [COORD_BITS-1:0]     req_end_y,
   input  logic [alps_pkg::COLOR_BITS-1:0]  req_line_color,
   output logic                             head_valid,
   input  logic                             head_pop,
   output alps_pkg::line_class_type         head_class,
   output logic signed [COORD_BITS-1:0]     head_col0,
   output logic signed [COORD_BITS-1:0]     head_col1,
   output logic signed [COORD_BITS-1:0]     head_row0,
   output logic signed [COORD_BITS-1:0]     head_row1,
   output logic [COORD_BITS-1:0]            head_dx,
   output logic [COORD_BITS-1:0]            head_mag,
   output logic [alps_pkg::COLOR_BITS-1:0]  head_color
);
   import alps_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C:0]   ddx, ddy;
   logic [C-1:0]        adx, ady;
   logic                steep, vertical, swap;
   logic signed [C-1:0] a0, a1, b0, b1;
   line_class_type      cls;
   logic signed [C-1:0] col0, col1, row0, row1;
   logic [C-1:0]        dx, mag;

   line_class_type       q_class_ff [2];
   logic signed [C-1:0]  q_col0_ff [2];
   logic signed [C-1:0]  q_col1_ff [2];
   logic signed [C-1:0]  q_row0_ff [2];
   logic signed [C-1:0]  q_row1_ff [2];
   logic [C-1:0]         q_dx_ff [2];
   logic [C-1:0]         q_mag_ff [2];
   logic [COLOR_BITS-1:0] q_color_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   always_comb begin
      ddx = {req_end_x[C-1], req_end_x} - {req_start_x[C-1], req_start_x};
      ddy = {req_end_y[C-1], req_end_y} - {req_start_y[C-1], req_start_y};
      adx = ddx[C] ? C'(-ddx) : ddx[C-1:0];
      ady = ddy[C] ? C'(-ddy) : ddy[C-1:0];
      vertical = (req_start_x == req_end_x);
      steep = !vertical && (ady > adx);
      a0 = steep ? req_start_y : req_start_x;
      b0 = steep ? req_start_x : req_start_y;
      a1 = steep ? req_end_y : req_end_x;
      b1 = steep ? req_end_x : req_end_y;
      swap = a0 > a1;
      if (vertical) begin
         col0 = (req_start_y < req_end_y) ? req_start_y : req_end_y;
         col1 = (req_start_y < req_end_y) ? req_end_y : req_start_y;
         row0 = req_start_x;
         row1 = req_start_x;
      end else begin
         col0 = swap ? a1 : a0;
         col1 = swap ? a0 : a1;
         row0 = swap ? b1 : b0;
         row1 = swap ? b0 : b1;
      end
      dx  = steep ? ady : adx;
      mag = steep ? adx : ady;
      cls.kind     = req_type;
      cls.vertical = vertical;
      cls.steep    = steep;
      cls.negative = (ddx[C] ^ ddy[C]) && (ddx != '0) && (ddy != '0);
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_class_ff[wr_ptr_ff] <= cls;
         q_col0_ff[wr_ptr_ff]  <= col0;
         q_col1_ff[wr_ptr_ff]  <= col1;
         q_row0_ff[wr_ptr_ff]  <= row0;
         q_row1_ff[wr_ptr_ff]  <= row1;
         q_dx_ff[wr_ptr_ff]    <= dx;
         q_mag_ff[wr_ptr_ff]   <= mag;
         q_color_ff[wr_ptr_ff] <= req_line_color;
      end
   end

   assign head_class = q_class_ff[rd_ptr_ff];
   assign head_col0  = q_col0_ff[rd_ptr_ff];
   assign head_col1  = q_col1_ff[rd_ptr_ff];
   assign head_row0  = q_row0_ff[rd_ptr_ff];
   assign head_row1  = q_row1_ff[rd_ptr_ff];
   assign head_dx    = q_dx_ff[rd_ptr_ff];
   assign head_mag   = q_mag_ff[rd_ptr_ff];
   assign head_color = q_color_ff[rd_ptr_ff];

endmodule

/* rtl/core/alps_divider.sv */
module alps_divider #(
   parameter int NUM_BITS = 29,
   parameter int DEN_BITS = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNTW = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DEN_BITS:0]   shifted, diff;
   logic                ge;

   always_comb begin
      shifted  = {rem_ff, quot_ff[NUM_BITS-1]};
      diff     = shifted - {1'b0, den_ff};
      ge       = (shifted >= {1'b0, den_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNTW'(NUM_BITS);
         quot_in  = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in   = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
         quot_in  = {quot_ff[NUM_BITS-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/core/alps_back.sv */
module alps_back #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   output logic                              head_pop,
   input  alps_pkg::line_class_type          head_class,
   input  logic signed [COORD_BITS-1:0]      head_col0,
   input  logic signed [COORD_BITS-1:0]      head_col1,
   input  logic signed [COORD_BITS-1:0]      head_row0,
   input  logic signed [COORD_BITS-1:0]      head_row1,
   input  logic [COORD_BITS-1:0]             head_dx,
   input  logic [COORD_BITS-1:0]             head_mag,
   input  logic [alps_pkg::COLOR_BITS-1:0]   head_color,
   input  logic [alps_pkg::CSR_BITS-1:0]     image_width,
   input  logic [alps_pkg::CSR_BITS-1:0]     image_height,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [COORD_BITS:0]        rsp_pixel_x,
   output logic signed [COORD_BITS:0]        rsp_pixel_y,
   output logic [alps_pkg::COLOR_BITS-1:0]   rsp_pixel_argb,
   output logic                              rsp_on_image,
   output logic                              rsp_line_done
);
   import alps_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int NW   = C + F;
   localparam int AW   = C + F + 1;
   localparam int PW   = C + 2;
   localparam int CMPW = (PW > CSR_BITS) ? PW : CSR_BITS;

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_DIV = 2'b10
   } ctl_state_type;

   typedef enum logic [5:0] {
      PH_END0_HI = 6'b000001,
      PH_END0_LO = 6'b000010,
      PH_END1_HI = 6'b000100,
      PH_END1_LO = 6'b001000,
      PH_INT_HI  = 6'b010000,
      PH_INT_LO  = 6'b100000
   } phase_type;

   ctl_state_type       state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic                active_ff, active_in;
   line_class_type      cls_ff, cls_in;
   logic signed [C-1:0] cur_ff, cur_in, last_ff, last_in;
   logic signed [C-1:0] row0_ff, row0_in, row1_ff, row1_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic signed [F+1:0]   slope_ff, slope_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [C:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COLOR_BITS-1:0] rsp_argb_ff, rsp_argb_in;
   logic                rsp_on_ff, rsp_on_in, rsp_done_ff, rsp_done_in;

   logic                div_start, div_done;
   logic [NW-1:0]       div_numer, div_quot;
   logic [F:0]          q;

   logic                out_free, emit;
   logic signed [C:0]   span;
   logic signed [C:0]   acc_floor;
   logic [F-1:0]        acc_frac;
   logic signed [PW-1:0] col_p, row_p, px, py;
   logic [F:0]          cov;
   logic                done_p;
   logic [CHAN_BITS+F:0] prod_r, prod_g, prod_b;
   logic [CMPW-1:0]     ux, uy;

   assign div_numer = {head_mag, {F{1'b0}}} + NW'(head_dx >> 1);

   alps_divider #(
      .NUM_BITS(NW),
      .DEN_BITS(C)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (head_dx),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign q         = div_quot[F:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign span      = {last_ff[C-1], last_ff} - {cur_ff[C-1], cur_ff};
   assign acc_floor = acc_ff[AW-1:F];
   assign acc_frac  = acc_ff[F-1:0];

   // pixel and weight of the current step, swapped back to x and y; vertical lines step down rows
   always_comb begin
      col_p  = {{2{cur_ff[C-1]}}, cur_ff};
      row_p  = {{2{row0_ff[C-1]}}, row0_ff};
      cov    = {1'b1, {F{1'b0}}};
      done_p = 1'b0;
      if (cls_ff.vertical) begin
         done_p = (span <= $signed((C+1)'(0)));
      end else begin
         unique case (phase_ff)
            PH_END0_HI: ;
            PH_END0_LO: begin
               row_p = {{2{row0_ff[C-1]}}, row0_ff} + PW'(1);
               cov   = '0;
            end
            PH_END1_HI: begin
               col_p = {{2{last_ff[C-1]}}, last_ff};
               row_p = {{2{row1_ff[C-1]}}, row1_ff};
            end
            PH_END1_LO: begin
               col_p  = {{2{last_ff[C-1]}}, last_ff};
               row_p  = {{2{row1_ff[C-1]}}, row1_ff} + PW'(1);
               cov    = '0;
               done_p = (span < $signed((C+1)'(2)));
            end
            PH_INT_HI: begin
               row_p = {acc_floor[C], acc_floor};
               cov   = {1'b1, {F{1'b0}}} - {1'b0, acc_frac};
            end
            PH_INT_LO: begin
               row_p  = {acc_floor[C], acc_floor} + PW'(1);
               cov    = {1'b0, acc_frac};
               done_p = (span <= $signed((C+1)'(1)));
            end
            default: ;
         endcase
      end
      px = (cls_ff.steep || cls_ff.vertical) ? row_p : col_p;
      py = (cls_ff.steep || cls_ff.vertical) ? col_p : row_p;
      prod_r = color_ff[23:16] * cov;
      prod_g = color_ff[15:8] * cov;
      prod_b = color_ff[7:0] * cov;
      ux = CMPW'($unsigned(px));
      uy = CMPW'($unsigned(py));
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      cls_in    = cls_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      row0_in   = row0_ff;
      row1_in   = row1_ff;
      acc_in    = acc_ff;
      slope_in  = slope_ff;
      color_in  = color_ff;
      head_pop  = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (head_valid) begin
               if (head_class.kind == REQ_LOAD) begin
                  // take the new line; any old one is dropped
                  head_pop  = 1'b1;
                  active_in = 1'b1;
                  phase_in  = PH_END0_HI;
                  cls_in    = head_class;
                  cur_in    = head_col0;
                  last_in   = head_col1;
                  row0_in   = head_row0;
                  row1_in   = head_row1;
                  color_in  = head_color;
                  if (!head_class.vertical) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end else if (out_free) begin
                  head_pop = 1'b1;
                  if (active_ff) begin
                     emit = 1'b1;
                     if (cls_ff.vertical) begin
                        if (done_p) active_in = 1'b0;
                        else cur_in = cur_ff + C'(1);
                     end else begin
                        unique case (phase_ff)
                           PH_END0_HI: phase_in = PH_END0_LO;
                           PH_END0_LO: phase_in = PH_END1_HI;
                           PH_END1_HI: phase_in = PH_END1_LO;
                           PH_END1_LO: begin
                              if (done_p) begin
                                 active_in = 1'b0;
                              end else begin
                                 cur_in   = cur_ff + C'(1);
                                 phase_in = PH_INT_HI;
                              end
                           end
                           PH_INT_HI: phase_in = PH_INT_LO;
                           PH_INT_LO: begin
                              if (done_p) begin
                                 active_in = 1'b0;
                              end else begin
                                 acc_in   = acc_ff + {{(AW-F-2){slope_ff[F+1]}}, slope_ff};
                                 cur_in   = cur_ff + C'(1);
                                 phase_in = PH_INT_HI;
                              end
                           end
                           default: active_in = 1'b0;
                        endcase
                     end
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in = cls_ff.negative ? -$signed({1'b0, q}) : $signed({1'b0, q});
               acc_in   = $signed({row0_ff[C-1], row0_ff, {F{1'b0}}})
                          + {{(AW-F-2){slope_in[F+1]}}, slope_in};
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_argb_in  = rsp_argb_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = px[C:0];
         rsp_y_in     = py[C:0];
         rsp_argb_in  = {ALPHA_OPAQUE, prod_r[CHAN_BITS+F-1:F],
                         prod_g[CHAN_BITS+F-1:F], prod_b[CHAN_BITS+F-1:F]};
         rsp_on_in    = !px[PW-1] && !py[PW-1]
                        && (ux < CMPW'(image_width)) && (uy < CMPW'(image_height));
         rsp_done_in  = done_p;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         phase_ff     <= PH_END0_HI;
         active_ff    <= 1'b0;
         cls_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         cls_ff       <= cls_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      row0_ff     <= row0_in;
      row1_ff     <= row1_in;
      acc_ff      <= acc_in;
      slope_ff    <= slope_in;
      color_ff    <= color_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_argb_ff <= rsp_argb_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_pixel_argb = rsp_argb_ff;
   assign rsp_on_image   = rsp_on_ff;
   assign rsp_line_done  = rsp_done_ff;

endmodule

/* rtl/core/antialiased_line_pixel_stepper_unit.sv */
// Channel  Direction  Handshake              Carries
// req      in         req_valid / req_stall  load (end points, color) or advance
// rsp      out        rsp_valid / rsp_stall  one pixel: position, ARGB, flags
// csr      in         csr_valid / csr_ready  image width (index 0) or height (1)
//
// The front takes one item per cycle into a two-entry queue while it has room.
// An advance is popped once no divide runs and the output register is free; while a line
// is active its pixel is registered there. Unstalled back-to-back advances give one per cycle.
// A non-vertical load holds the back end in its divide state until the slope divider,
// retiring one quotient bit per cycle, is done; a vertical load skips the divide.
// Reset is synchronous; it empties the queue and the output and drops any line.
// A stalled result holds in the output register; the front keeps filling the queue.
module antialiased_line_pixel_stepper_unit #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  alps_pkg::req_kind_type           req_type,
   input  logic signed [COORD_BITS-1:0]     req_start_x,
   input  logic signed [COORD_BITS-1:0]     req_start_y,
   input  logic signed [COORD_BITS-1:0]     req_end_x,
   input  logic signed [COORD_BITS-1:0]     req_end_y,
   input  logic [alps_pkg::COLOR_BITS-1:0]  req_line_color,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [COORD_BITS:0]       rsp_pixel_x,
   output logic signed [COORD_BITS:0]       rsp_pixel_y,
   output logic [alps_pkg::COLOR_BITS-1:0]  rsp_pixel_argb,
   output logic                             rsp_on_image,
   output logic                             rsp_line_done,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  alps_pkg::csr_reg_type            csr_index,
   input  logic [alps_pkg::CSR_BITS-1:0]    csr_data
);
   import alps_pkg::*;

   logic [CSR_BITS-1:0] width_ff, width_in, height_ff, height_in;

   logic                         head_valid, head_pop;
   line_class_type               head_class;
   logic signed [COORD_BITS-1:0] head_col0, head_col1, head_row0, head_row1;
   logic [COORD_BITS-1:0]        head_dx, head_mag;
   logic [COLOR_BITS-1:0]        head_color;

   // the user must write only while idle; the block does not enforce it and always takes them
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // front: classify each transfer and queue it
   alps_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .head_class     (head_class),
      .head_col0      (head_col0),
      .head_col1      (head_col1),
      .head_row0      (head_row0),
      .head_row1      (head_row1),
      .head_dx        (head_dx),
      .head_mag       (head_mag),
      .head_color     (head_color)
   );

   // back: slope divide on a non-vertical load, one pixel per advance while a line is active
   alps_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .head_class     (head_class),
      .head_col0      (head_col0),
      .head_col1      (head_col1),
      .head_row0      (head_row0),
      .head_row1      (head_row1),
      .head_dx        (head_dx),
      .head_mag       (head_mag),
      .head_color     (head_color),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_argb (rsp_pixel_argb),
      .rsp_on_image   (rsp_on_image),
      .rsp_line_done  (rsp_line_done)
   );

endmodule
